/* hw/rtl/base64_stream_codec_unit_defines.svh */
// Assertion macros shared by the Base64 stream codec RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef BASE64_STREAM_CODEC_UNIT_DEFINES_SVH
`define BASE64_STREAM_CODEC_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define B64SC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define B64SC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/b64sc_pkg.sv */
// Types, character constants and alphabet functions for the Base64 stream codec.
// No dependencies; imported by every codec module.
`timescale 1ns / 1ps

package b64sc_pkg;

   // Mode register codes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // ASCII anchors of the alphabet
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   // Sextet value of the plus symbol character
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;

   // Up to four responses produced by one request
   typedef struct packed {
      logic [3:0][7:0] chr;      // response bytes, slot 0 first
      logic [1:0]      cnt;      // number of responses minus one
      logic            valid;    // 0 for a bare end marker
      logic            last;     // final response of the job closes the message
      logic            stopped;  // decode halted at a foreign character
   } job_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] sextet;
   } dec_type;

   // Map a sextet to its alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] s);
      logic [7:0] s8;
      s8 = {2'b00, s};
      if (s < 6'd26) return CHAR_UPPER_A + s8;
      if (s < 6'd52) return CHAR_LOWER_A + s8 - 8'd26;
      if (s < 6'd62) return CHAR_DIGIT_0 + s8 - 8'd52;
      if (s == SEXTET_PLUS) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // Map a character to its sextet; ok is low outside the alphabet
   function automatic dec_type dec_char(input logic [7:0] c);
      dec_type d;
      d.ok     = 1'b1;
      d.sextet = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d.sextet = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d.sextet = 6'(c - CHAR_LOWER_A + 8'd26);
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d.sextet = 6'(c - CHAR_DIGIT_0 + 8'd52);
      end else if (c == CHAR_PLUS) begin
         d.sextet = 6'd62;
      end else if (c == CHAR_SLASH) begin
         d.sextet = 6'd63;
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

/* hw/rtl/b64sc_front.sv */
// Front end of the Base64 stream codec: holds the message state and turns each
// request into at most one job of up to four responses. Depends on b64sc_pkg.
`timescale 1ns / 1ps

module b64sc_front
   import b64sc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [0:0] csr_wdata,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       job_push,
   output job_type    job
);

   logic       mode_ff, mode_in;
   logic [5:0] buf_ff, buf_in;
   logic [2:0] bcnt_ff, bcnt_in;
   logic       halted_ff, halted_in;
   logic [1:0] cc_ff, cc_in;

   // encode path
   logic [5:0] s0, s1, flush;
   logic [1:0] nreal;
   logic [2:0] brem;
   logic       flush_en;
   logic [2:0] n0, total, capped;
   logic [1:0] cc_mid, pads;
   job_type    enc_job;

   // decode path
   dec_type    dec;
   logic       has_byte, dec_halt;
   logic [7:0] dec_byte;
   logic [2:0] dec_brem;
   job_type    dec_job;

   // Build the encode job: one or two sextets, then flush and padding on last
   always_comb begin
      s0    = in_byte[7:2];
      s1    = in_byte[5:0];
      nreal = 2'd1;
      brem  = 3'd2;
      flush = {in_byte[1:0], 4'b0000};
      case (bcnt_ff)
         3'd2: begin
            s0    = {buf_ff[1:0], in_byte[7:4]};
            brem  = 3'd4;
            flush = {in_byte[3:0], 2'b00};
         end
         3'd4: begin
            s0    = {buf_ff[3:0], in_byte[7:6]};
            nreal = 2'd2;
            brem  = 3'd0;
         end
         default: begin
            s0 = in_byte[7:2];
         end
      endcase
      flush_en = (brem != 3'd0);
      n0       = 3'(nreal) + 3'(in_last & flush_en);
      cc_mid   = cc_ff + n0[1:0];
      pads     = 2'b00 - cc_mid;
      total    = n0 + {1'b0, pads};
      capped   = (total > 3'd4) ? 3'd4 : total;

      enc_job.chr[0]  = enc_char(s0);
      enc_job.chr[1]  = (nreal == 2'd2) ? enc_char(s1)
                        : (flush_en ? enc_char(flush) : CHAR_PAD);
      enc_job.chr[2]  = CHAR_PAD;
      enc_job.chr[3]  = CHAR_PAD;
      enc_job.cnt     = in_last ? 2'(capped - 3'd1) : 2'(nreal - 2'd1);
      enc_job.valid   = 1'b1;
      enc_job.last    = in_last;
      enc_job.stopped = 1'b0;
   end

   // Build the decode job: at most one byte, or a bare end marker on last
   always_comb begin
      dec      = dec_char(in_byte);
      has_byte = 1'b0;
      dec_byte = '0;
      dec_brem = bcnt_ff;
      dec_halt = halted_ff;
      if (!halted_ff) begin
         if (!dec.ok) begin
            dec_halt = 1'b1;
         end else begin
            case (bcnt_ff)
               3'd2: begin
                  has_byte = 1'b1;
                  dec_byte = {buf_ff[1:0], dec.sextet};
                  dec_brem = 3'd0;
               end
               3'd4: begin
                  has_byte = 1'b1;
                  dec_byte = {buf_ff[3:0], dec.sextet[5:2]};
                  dec_brem = 3'd2;
               end
               3'd6: begin
                  has_byte = 1'b1;
                  dec_byte = {buf_ff[5:0], dec.sextet[5:4]};
                  dec_brem = 3'd4;
               end
               default: begin
                  dec_brem = 3'd6;
               end
            endcase
         end
      end
      dec_job.chr     = {24'h000000, dec_byte};
      dec_job.cnt     = 2'd0;
      dec_job.valid   = has_byte;
      dec_job.last    = in_last;
      dec_job.stopped = in_last & dec_halt;
   end

   // Select the job and the next message state
   always_comb begin
      mode_in   = mode_ff;
      buf_in    = buf_ff;
      bcnt_in   = bcnt_ff;
      halted_in = halted_ff;
      cc_in     = cc_ff;
      if (mode_ff == MODE_DECODE) begin
         job      = dec_job;
         job_push = accept & (has_byte | in_last);
      end else begin
         job      = enc_job;
         job_push = accept;
      end
      if (csr_we) begin
         mode_in   = csr_wdata[0];
         buf_in    = '0;
         bcnt_in   = '0;
         halted_in = 1'b0;
         cc_in     = '0;
      end else if (accept) begin
         if (in_last) begin
            buf_in    = '0;
            bcnt_in   = '0;
            halted_in = 1'b0;
            cc_in     = '0;
         end else if (mode_ff == MODE_DECODE) begin
            halted_in = dec_halt;
            if (!dec_halt) begin
               buf_in  = dec.sextet;
               bcnt_in = dec_brem;
            end
         end else begin
            buf_in  = in_byte[5:0];
            bcnt_in = brem;
            cc_in   = cc_ff + nreal;
         end
      end
   end

   // Hold mode and message state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ENCODE;
         buf_ff    <= '0;
         bcnt_ff   <= '0;
         halted_ff <= 1'b0;
         cc_ff     <= '0;
      end else begin
         mode_ff   <= mode_in;
         buf_ff    <= buf_in;
         bcnt_ff   <= bcnt_in;
         halted_ff <= halted_in;
         cc_ff     <= cc_in;
      end
   end

endmodule

/* hw/rtl/b64sc_queue.sv */
// Job queue between front and back of the Base64 stream codec, built from
// registers with read and write pointers. Depends on b64sc_pkg and the defines header.
`timescale 1ns / 1ps
`include "base64_stream_codec_unit_defines.svh"

module b64sc_queue
   import b64sc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store jobs; no reset on payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `B64SC_ASSERT(a_q_bound, clock, reset, count_ff <= CW'(DEPTH), "queue count over depth")
   `B64SC_ASSERT(a_q_grow, clock, reset, (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue count did not grow")
   `B64SC_ASSERT(a_q_full_ptr, clock, reset, full |-> (wr_ptr_ff == rd_ptr_ff), "full queue with pointers apart")
   `B64SC_ASSERT_ALWAYS(a_q_reset, clock, reset |=> empty, "queue not empty after reset")

endmodule

/* hw/rtl/b64sc_back.sv */
// Back end of the Base64 stream codec: takes queued jobs and shows responses
// one per cycle while popped. Depends on b64sc_pkg and the defines header.
`timescale 1ns / 1ps
`include "base64_stream_codec_unit_defines.svh"

module b64sc_back
   import b64sc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_out_last,
   output logic       rsp_out_stopped
);

   job_type    cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       take, at_end, load;

   assign take   = rsp_pop & busy_ff;
   assign at_end = (idx_ff == cur_ff.cnt);
   assign load   = ~busy_ff | (take & at_end);
   assign q_pop  = load & ~q_empty;

   // Present the current response
   assign rsp_empty       = ~busy_ff;
   assign rsp_out_byte    = cur_ff.chr[idx_ff];
   assign rsp_out_valid   = cur_ff.valid;
   assign rsp_out_last    = cur_ff.last & at_end;
   assign rsp_out_stopped = cur_ff.stopped;

   // Step through the job, reload from the queue when it is drained
   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         busy_in = ~q_empty;
         idx_in  = '0;
         if (!q_empty) begin
            cur_in = head_job;
         end
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // Hold the job payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `B64SC_ASSERT(a_bk_idx, clock, reset, busy_ff |-> (idx_ff <= cur_ff.cnt), "response index past job end")
   `B64SC_ASSERT(a_bk_marker, clock, reset, (busy_ff && !cur_ff.valid) |-> (cur_ff.last && cur_ff.cnt == 2'd0), "bare end marker not a single final response")
   `B64SC_ASSERT(a_bk_drain, clock, reset, (take && at_end && q_empty) |=> rsp_empty, "response shown after queue drained")

endmodule

/* hw/rtl/base64_stream_codec_unit.sv */
// Base64 stream codec, top level: mode register, front end, job queue, back end.
// Depends on b64sc_pkg, b64sc_front, b64sc_queue and b64sc_back.
//   Usage:
//   Requests enter on req_push/req_full with req_in_byte and req_in_last; one
//   request is one raw byte (encode) or one character (decode).
//   Responses leave on rsp_empty/rsp_pop; the oldest response sits on rsp_out_*
//   while rsp_empty is low. Encode gives one or two characters per byte and up to
//   four on the last byte (flush and '=' padding); decode gives at most one byte
//   per character, and a bare end marker (rsp_out_valid low) on a last request
//   that yields no byte.
//   csr_we writes csr_wdata as the mode (0 encode, 1 decode) and drops any
//   message in progress; write only while no response is pending.
//   A request's job is registered in the job queue, then in the back end, before its first response shows.
//   The back end emits one response per cycle while rsp_pop is high. The job
//   queue lets the front take requests while the back drains; req_full rises
//   when the queue holds QUEUE_DEPTH jobs, and stays high while the receiver
//   holds rsp_pop low.
//   Reset (synchronous, active high) selects encode and empties everything.
`timescale 1ns / 1ps

module base64_stream_codec_unit
   import b64sc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [0:0] csr_wdata,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_out_last,
   output logic       rsp_out_stopped
);

   logic    accept;
   logic    job_push;
   job_type job;
   logic    q_full, q_empty, q_pop;
   job_type head_job;

   // Accept a request whenever the queue has room
   assign accept   = req_push & ~q_full;
   assign req_full = q_full;

   b64sc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .job_push  (job_push),
      .job       (job)
   );

   b64sc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   b64sc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_out_last    (rsp_out_last),
      .rsp_out_stopped (rsp_out_stopped)
   );

endmodule
